// ===== rtl/battery_charge_voltage_model_macros.svh =====
// ----------------------------------------------------------------------------
// Battery charge voltage model assertion macros
// Clocked assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BATTERY_CHARGE_VOLTAGE_MODEL_MACROS_SVH
`define BATTERY_CHARGE_VOLTAGE_MODEL_MACROS_SVH

// Assertion that is disabled while reset is asserted.
`define BCVM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("%m: assertion failed");

// Assertion that is also checked while reset is asserted.
`define BCVM_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("%m: assertion failed");

`endif

// ===== rtl/bcvm_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery charge voltage model package
// Command codes, register indexes, widths, FSM states and control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcvm_pkg;

	typedef enum logic [1:0] {
		CMD_STEP    = 2'd0,
		CMD_WR_VOLT = 2'd1,
		CMD_WR_RES  = 2'd2,
		CMD_INIT    = 2'd3
	} cmd_t;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_CHARGE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LEAK_COEFF     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_COEFF  = 2'd2;

	localparam int CMD_W       = 2;
	localparam int INDEX_W     = 7;
	localparam int WORD_W      = 32;
	localparam int UV_W        = 24;
	localparam int LEVEL_W     = 30;
	localparam int CHARGE_W    = 62;
	localparam int LEAK_SHIFT  = 6;
	localparam int DELTA_SHIFT = 2;
	localparam int DROP_SHIFT  = 28;
	localparam int OCV_FRAC    = 8;
	localparam int LEVEL_LSB   = CHARGE_W - LEVEL_W;
	localparam int PROD_W      = 2 * WORD_W;
	localparam int LEAK_W      = WORD_W - LEAK_SHIFT + WORD_W;
	localparam int DROP_W      = PROD_W - DROP_SHIFT;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LEAK,
		ST_DELTA,
		ST_LOAD,
		ST_READ,
		ST_DROP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		cmd_t cmd;
		logic mul_en;
		logic leak_en;
		logic delta_en;
		logic load_en;
		logic rd_en;
		logic drop_en;
		logic out_load;
	} ctrl_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/bcvm_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bcvm_req_if;
	import bcvm_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [INDEX_W-1:0] table_index;
	logic [WORD_W-1:0]  table_word;
	logic [WORD_W-1:0]  current;
	logic               charging;

	modport source (
		output valid, cmd, table_index, table_word, current, charging,
		input  ready
	);

	modport sink (
		input  valid, cmd, table_index, table_word, current, charging,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/bcvm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bcvm_rsp_if;
	import bcvm_pkg::*;

	logic               valid;
	logic               ready;
	logic [WORD_W-1:0]  cell_voltage;
	logic [UV_W-1:0]    open_circuit_uv;
	logic [LEVEL_W-1:0] charge_level;

	modport source (
		output valid, cell_voltage, open_circuit_uv, charge_level,
		input  ready
	);

	modport sink (
		input  valid, cell_voltage, open_circuit_uv, charge_level,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/bcvm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcvm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

`default_nettype wire

// ===== rtl/bcvm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sequencer
// Steps one command through multiply, charge update, table read and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcvm_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [bcvm_pkg::CMD_W-1:0] in_cmd,
	output      logic                       in_ready,
	input  wire bcvm_pkg::status_t          st,
	output      bcvm_pkg::ctrl_t            ctl
);
	import bcvm_pkg::*;

	state_t state_q;
	state_t state_d;
	cmd_t   cmd_q;
	cmd_t   cmd_in;
	logic   accept;

	assign cmd_in = cmd_t'(in_cmd);
	assign accept = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_in)
						CMD_STEP: state_d = ST_MUL;
						CMD_INIT: state_d = ST_LOAD;
						default:  state_d = ST_OUT;
					endcase
				end
			end
			ST_MUL:   state_d = ST_LEAK;
			ST_LEAK:  state_d = ST_DELTA;
			ST_DELTA: state_d = ST_READ;
			ST_LOAD:  state_d = ST_READ;
			ST_READ:  state_d = ST_DROP;
			ST_DROP:  state_d = ST_OUT;
			ST_OUT: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		ctl.accept   = accept;
		ctl.cmd      = cmd_q;
		ctl.mul_en   = (state_q == ST_MUL);
		ctl.leak_en  = (state_q == ST_LEAK);
		ctl.delta_en = (state_q == ST_DELTA);
		ctl.load_en  = (state_q == ST_LOAD);
		ctl.rd_en    = (state_q == ST_READ);
		ctl.drop_en  = (state_q == ST_DROP);
		ctl.out_load = (state_q == ST_OUT) && st.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_in;
		end
	end
endmodule

`default_nettype wire

// ===== rtl/bcvm_core.sv =====
// ----------------------------------------------------------------------------
// Datapath
// Charge accumulator, leakage and current products, voltage drop and
// the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcvm_core #(
	parameter int ADDR_W = 7
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire bcvm_pkg::ctrl_t                  ctl,
	output      bcvm_pkg::status_t                st,
	input  wire logic                             cfg_we,
	input  wire logic [bcvm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [bcvm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [bcvm_pkg::WORD_W-1:0]      in_current,
	input  wire logic                             in_charging,
	output      logic                             ram_re,
	output      logic [ADDR_W-1:0]                ram_raddr,
	input  wire logic [bcvm_pkg::WORD_W-1:0]      volt_rdata,
	input  wire logic [bcvm_pkg::WORD_W-1:0]      res_rdata,
	output      logic                             out_valid,
	input  wire logic                             out_ready,
	output      logic [bcvm_pkg::WORD_W-1:0]      out_cell_voltage,
	output      logic [bcvm_pkg::UV_W-1:0]        out_open_circuit_uv,
	output      logic [bcvm_pkg::LEVEL_W-1:0]     out_charge_level
);
	import bcvm_pkg::*;

	localparam logic [CHARGE_W-1:0] CHARGE_MAX = {CHARGE_W{1'b1}};

	logic [LEVEL_W-1:0]  initial_q;
	logic [WORD_W-1:0]   leak_coeff_q;
	logic [WORD_W-1:0]   current_coeff_q;

	logic [CHARGE_W-1:0] charge_q;
	logic [WORD_W-1:0]   ocv_q;
	logic [WORD_W-1:0]   current_q;
	logic                charging_q;

	logic [LEAK_W-1:0]   leak_s1;
	logic [CHARGE_W-1:0] delta_s1;
	logic [DROP_W-1:0]   vdrop_q;

	logic                out_valid_q;
	logic [WORD_W-1:0]   cell_q;
	logic [UV_W-1:0]     uv_q;
	logic [LEVEL_W-1:0]  level_q;

	logic [LEAK_W-1:0]   leak_prod;
	logic [PROD_W-1:0]   delta_prod;
	logic [PROD_W-1:0]   drop_prod;
	logic [CHARGE_W-1:0] leak_ext;
	logic [CHARGE_W-1:0] after_leak;
	logic [CHARGE_W:0]   charge_sum;
	logic [CHARGE_W-1:0] after_delta;
	logic [DROP_W:0]     cell_sum;
	logic [DROP_W-1:0]   cell_diff;
	logic [DROP_W-1:0]   ocv_ext;
	logic [WORD_W-1:0]   cell_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_q       <= '0;
			leak_coeff_q    <= '0;
			current_coeff_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INITIAL_CHARGE: initial_q       <= cfg_data[LEVEL_W-1:0];
				REG_LEAK_COEFF:     leak_coeff_q    <= cfg_data[WORD_W-1:0];
				REG_CURRENT_COEFF:  current_coeff_q <= cfg_data[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	assign leak_prod  = LEAK_W'(ocv_q[WORD_W-1:LEAK_SHIFT]) * LEAK_W'(leak_coeff_q);
	assign delta_prod = PROD_W'(current_q) * PROD_W'(current_coeff_q);
	assign drop_prod  = PROD_W'(current_q) * PROD_W'(res_rdata);

	assign leak_ext   = CHARGE_W'(leak_s1);
	assign after_leak = (leak_ext > charge_q) ? '0 : (charge_q - leak_ext);

	assign charge_sum = {1'b0, charge_q} + {1'b0, delta_s1};

	always_comb begin
		if (charging_q) begin
			after_delta = charge_sum[CHARGE_W] ? CHARGE_MAX : charge_sum[CHARGE_W-1:0];
		end else begin
			after_delta = (delta_s1 > charge_q) ? '0 : (charge_q - delta_s1);
		end
	end

	assign ocv_ext   = DROP_W'(ocv_q);
	assign cell_sum  = {1'b0, ocv_ext} + {1'b0, vdrop_q};
	assign cell_diff = ocv_ext - vdrop_q;

	always_comb begin
		if (ctl.cmd != CMD_STEP || charge_q == '0) begin
			cell_d = '0;
		end else if (charging_q) begin
			cell_d = (cell_sum[DROP_W:WORD_W] != '0) ? {WORD_W{1'b1}} : cell_sum[WORD_W-1:0];
		end else begin
			cell_d = (vdrop_q > ocv_ext) ? '0 : cell_diff[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_q <= '0;
			ocv_q    <= '0;
		end else begin
			if (ctl.leak_en) begin
				charge_q <= after_leak;
			end else if (ctl.delta_en) begin
				charge_q <= after_delta;
			end else if (ctl.load_en) begin
				charge_q <= {initial_q, {LEVEL_LSB{1'b0}}};
			end
			if (ctl.drop_en) begin
				ocv_q <= volt_rdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			current_q  <= in_current;
			charging_q <= in_charging;
		end
		if (ctl.mul_en) begin
			leak_s1  <= leak_prod;
			delta_s1 <= delta_prod[PROD_W-1:DELTA_SHIFT];
		end
		if (ctl.drop_en) begin
			vdrop_q <= drop_prod[PROD_W-1:DROP_SHIFT];
		end
		if (ctl.out_load) begin
			cell_q  <= cell_d;
			uv_q    <= ocv_q[WORD_W-1:OCV_FRAC];
			level_q <= charge_q[CHARGE_W-1:LEVEL_LSB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign st.out_free         = !out_valid_q || out_ready;
	assign ram_re              = ctl.rd_en;
	assign ram_raddr           = charge_q[CHARGE_W-1 -: ADDR_W];
	assign out_valid           = out_valid_q;
	assign out_cell_voltage    = cell_q;
	assign out_open_circuit_uv = uv_q;
	assign out_charge_level    = level_q;
endmodule

`default_nettype wire

// ===== rtl/battery_charge_voltage_model.sv =====
// Battery charge voltage model: a fixed-point battery emulator. Each request
// carries a command; every request returns exactly one response. A step
// command runs multiply, leakage subtract, current add, table read through
// the shared read address of both table RAMs and voltage drop multiply; an
// initialize loads the initial charge and reads the tables; a table write
// goes straight to the output. The request side accepts a new command while
// an earlier response still waits in the output register. Table entries are
// undefined after reset until written; the user must write configuration
// registers only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
// Battery charge voltage model top level
// Sequencer, datapath and the open-circuit voltage and resistance tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module battery_charge_voltage_model #(
	parameter int TABLE_LOG_SIZE = 7
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [bcvm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [bcvm_pkg::CFG_DATA_W-1:0]  cfg_data,
	bcvm_req_if.sink                              req,
	bcvm_rsp_if.source                            rsp
);
	import bcvm_pkg::*;

	localparam int ADDR_W = TABLE_LOG_SIZE;
	localparam int DEPTH  = 2 ** TABLE_LOG_SIZE;

	ctrl_t                    ctl;
	status_t                  st;
	logic [ADDR_W+INDEX_W-1:0] index_ext;
	logic [ADDR_W-1:0]        waddr;
	logic                     volt_we;
	logic                     res_we;
	logic                     ram_re;
	logic [ADDR_W-1:0]        ram_raddr;
	logic [WORD_W-1:0]        volt_rdata;
	logic [WORD_W-1:0]        res_rdata;

	assign index_ext = {{ADDR_W{1'b0}}, req.table_index};
	assign waddr     = index_ext[ADDR_W-1:0];
	assign volt_we   = ctl.accept && (cmd_t'(req.cmd) == CMD_WR_VOLT);
	assign res_we    = ctl.accept && (cmd_t'(req.cmd) == CMD_WR_RES);

	bcvm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_cmd   (req.cmd),
		.in_ready (req.ready),
		.st       (st),
		.ctl      (ctl)
	);

	bcvm_core #(
		.ADDR_W (ADDR_W)
	) u_core (
		.clk                 (clk),
		.arst_n              (arst_n),
		.ctl                 (ctl),
		.st                  (st),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_current          (req.current),
		.in_charging         (req.charging),
		.ram_re              (ram_re),
		.ram_raddr           (ram_raddr),
		.volt_rdata          (volt_rdata),
		.res_rdata           (res_rdata),
		.out_valid           (rsp.valid),
		.out_ready           (rsp.ready),
		.out_cell_voltage    (rsp.cell_voltage),
		.out_open_circuit_uv (rsp.open_circuit_uv),
		.out_charge_level    (rsp.charge_level)
	);

	bcvm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_volt_ram (
		.clk   (clk),
		.we    (volt_we),
		.waddr (waddr),
		.wdata (req.table_word),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (volt_rdata)
	);

	bcvm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_res_ram (
		.clk   (clk),
		.we    (res_we),
		.waddr (waddr),
		.wdata (req.table_word),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (res_rdata)
	);
endmodule

`default_nettype wire

// ===== rtl/bcvm_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Assertions on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "battery_charge_voltage_model_macros.svh"

module bcvm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] rsp_cell_voltage,
	input wire logic [23:0] rsp_open_circuit_uv,
	input wire logic [29:0] rsp_charge_level
);
	`BCVM_ASSERT(a_ready_drops, clk, arst_n, req_valid && req_ready |=> !req_ready)
	`BCVM_ASSERT(a_no_early_rsp, clk, arst_n, req_valid && req_ready |=> !$rose(rsp_valid))
	`BCVM_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_voltage) && $stable(rsp_open_circuit_uv) && $stable(rsp_charge_level))
	`BCVM_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !rsp_valid)
endmodule

bind battery_charge_voltage_model bcvm_checker u_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_cell_voltage    (rsp.cell_voltage),
	.rsp_open_circuit_uv (rsp.open_circuit_uv),
	.rsp_charge_level    (rsp.charge_level)
);

`default_nettype wire

// ===== tb/battery_charge_voltage_model_test.sv =====
// ----------------------------------------------------------------------------
// Battery charge voltage model testbench
// Drives command items through the request channel and predicts each response
// with a local copy of charge, open-circuit voltage and both tables. Table
// fill plus a random run, a directed pass over the saturation and empty-cell
// corners, then random sequences under several coefficient settings, with
// random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_charge_voltage_model_test;
	import bcvm_pkg::*;

	localparam int TABLE_LOG_SIZE = 7;
	localparam int TABLE_ENTRIES  = 1 << TABLE_LOG_SIZE;
	localparam logic [63:0] CHARGE_MAX = (64'd1 << CHARGE_W) - 64'd1;
	localparam logic [63:0] WORD_MAX   = 64'hFFFF_FFFF;

	typedef struct packed {
		cmd_t               cmd;
		logic [INDEX_W-1:0] table_index;
		logic [WORD_W-1:0]  table_word;
		logic [WORD_W-1:0]  current;
		logic               charging;
	} cell_command_t;

	typedef struct packed {
		logic [WORD_W-1:0]  cell_voltage;
		logic [UV_W-1:0]    open_circuit_uv;
		logic [LEVEL_W-1:0] charge_level;
	} cell_reading_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	bcvm_req_if req_ch ();
	bcvm_rsp_if rsp_ch ();

	battery_charge_voltage_model #(
		.TABLE_LOG_SIZE(TABLE_LOG_SIZE)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	logic [CHARGE_W-1:0] charge_state = '0;
	logic [WORD_W-1:0]   ocv_state = '0;
	logic [WORD_W-1:0]   volt_table [0:TABLE_ENTRIES-1];
	logic [WORD_W-1:0]   res_table [0:TABLE_ENTRIES-1];
	logic [LEVEL_W-1:0]  init_charge = '0;
	logic [WORD_W-1:0]   leak_coeff = '0;
	logic [WORD_W-1:0]   current_coeff = '0;

	cell_command_t command_backlog [$];
	cell_reading_t awaited_readings [$];
	int            pushed_count = 0;
	int            accepted_count = 0;
	int            answered_count = 0;
	int            fault_count = 0;
	int            cycle_no = 0;
	logic          req_taken = 1'b0;

	function automatic cell_reading_t advance_cell(cell_command_t c);
		cell_reading_t             r;
		logic [63:0]               leak;
		logic [63:0]               delta;
		logic [63:0]               level;
		logic [63:0]               drop;
		logic [TABLE_LOG_SIZE-1:0] pos;
		r.cell_voltage = '0;
		case (c.cmd)
			CMD_WR_VOLT: volt_table[c.table_index] = c.table_word;
			CMD_WR_RES: res_table[c.table_index] = c.table_word;
			CMD_INIT: begin
				charge_state = {init_charge, 32'd0};
				ocv_state = volt_table[charge_state[CHARGE_W-1 -: TABLE_LOG_SIZE]];
			end
			CMD_STEP: begin
				leak = {32'd0, ocv_state >> LEAK_SHIFT} * {32'd0, leak_coeff};
				delta = ({32'd0, c.current} * {32'd0, current_coeff}) >> DELTA_SHIFT;
				level = {2'd0, charge_state};
				level = (level < leak) ? 64'd0 : level - leak;
				if (c.charging) begin
					level = level + delta;
					if (level > CHARGE_MAX)
						level = CHARGE_MAX;
				end else begin
					level = (level < delta) ? 64'd0 : level - delta;
				end
				charge_state = level[CHARGE_W-1:0];
				pos = charge_state[CHARGE_W-1 -: TABLE_LOG_SIZE];
				ocv_state = volt_table[pos];
				drop = ({32'd0, c.current} * {32'd0, res_table[pos]}) >> DROP_SHIFT;
				if (c.charging) begin
					drop = drop + {32'd0, ocv_state};
					r.cell_voltage = (drop > WORD_MAX) ? '1 : drop[WORD_W-1:0];
				end else begin
					r.cell_voltage = (drop > {32'd0, ocv_state}) ? '0
						: ocv_state - drop[WORD_W-1:0];
				end
				if (charge_state == '0)
					r.cell_voltage = '0;
			end
		endcase
		r.open_circuit_uv = ocv_state[WORD_W-1 -: UV_W];
		r.charge_level = charge_state[CHARGE_W-1 -: LEVEL_W];
		return r;
	endfunction

	function automatic bit idle_draw();
		return (cycle_no % 4000 >= 800) && ($urandom_range(99) < 20);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(negedge clk) begin : drive_requests
		cell_command_t next_cmd;
		if (arst_n && (!req_ch.valid || req_taken)) begin
			if (command_backlog.size() != 0 && !idle_draw()) begin
				next_cmd = command_backlog.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.cmd <= next_cmd.cmd;
				req_ch.table_index <= next_cmd.table_index;
				req_ch.table_word <= next_cmd.table_word;
				req_ch.current <= next_cmd.current;
				req_ch.charging <= next_cmd.charging;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
		rsp_ch.ready <= arst_n && !idle_draw();
	end

	always @(posedge clk) begin : watch_channels
		cell_command_t seen;
		cell_reading_t got;
		cell_reading_t want;
		cycle_no <= cycle_no + 1;
		req_taken <= req_ch.valid && req_ch.ready;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			seen.cmd = cmd_t'(req_ch.cmd);
			seen.table_index = req_ch.table_index;
			seen.table_word = req_ch.table_word;
			seen.current = req_ch.current;
			seen.charging = req_ch.charging;
			awaited_readings.push_back(advance_cell(seen));
			accepted_count++;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.cell_voltage = rsp_ch.cell_voltage;
			got.open_circuit_uv = rsp_ch.open_circuit_uv;
			got.charge_level = rsp_ch.charge_level;
			if (awaited_readings.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected reading: cell %h ocv %h level %h",
						got.cell_voltage, got.open_circuit_uv, got.charge_level);
			end else begin
				want = awaited_readings.pop_front();
				answered_count++;
				if (got !== want) begin
					fault_count++;
					if (fault_count <= 10)
						$display("reading %0d: expected cell %h ocv %h level %h, got cell %h ocv %h level %h",
							answered_count, want.cell_voltage, want.open_circuit_uv,
							want.charge_level, got.cell_voltage, got.open_circuit_uv,
							got.charge_level);
				end
			end
		end
	end

	task automatic queue_item(cmd_t cmd, logic [INDEX_W-1:0] index, logic [WORD_W-1:0] word,
		logic [WORD_W-1:0] cur, logic chg);
		cell_command_t c;
		c.cmd = cmd;
		c.table_index = index;
		c.table_word = word;
		c.current = cur;
		c.charging = chg;
		command_backlog.push_back(c);
		pushed_count++;
	endtask

	task automatic drain();
		wait (accepted_count == pushed_count && answered_count == pushed_count);
		@(negedge clk);
	endtask

	task automatic set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		case (index)
			REG_INITIAL_CHARGE: init_charge = value[LEVEL_W-1:0];
			REG_LEAK_COEFF: leak_coeff = value;
			REG_CURRENT_COEFF: current_coeff = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(logic [CFG_DATA_W-1:0] charge0, logic [CFG_DATA_W-1:0] leak,
		logic [CFG_DATA_W-1:0] coeff);
		set_reg(REG_INITIAL_CHARGE, charge0);
		set_reg(REG_LEAK_COEFF, leak);
		set_reg(REG_CURRENT_COEFF, coeff);
	endtask

	task automatic queue_random(int count);
		logic chg_run;
		int   pick;
		chg_run = 1'($urandom_range(1));
		repeat (count) begin
			pick = $urandom_range(99);
			if ($urandom_range(99) < 15)
				chg_run = ~chg_run;
			if (pick < 70)
				queue_item(CMD_STEP, INDEX_W'($urandom_range(127)), $urandom,
					$urandom >> $urandom_range(32), chg_run);
			else if (pick < 80)
				queue_item(CMD_INIT, INDEX_W'($urandom_range(127)), $urandom, $urandom,
					1'($urandom_range(1)));
			else if (pick < 90)
				queue_item(CMD_WR_VOLT, INDEX_W'($urandom_range(127)), $urandom, $urandom,
					1'($urandom_range(1)));
			else
				queue_item(CMD_WR_RES, INDEX_W'($urandom_range(127)),
					$urandom >> $urandom_range(32), $urandom, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = '0;
		req_ch.table_index = '0;
		req_ch.table_word = '0;
		req_ch.current = '0;
		req_ch.charging = 1'b0;
		rsp_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill both tables before any read can reach them
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			queue_item(CMD_WR_VOLT, i[INDEX_W-1:0], $urandom, $urandom,
				1'($urandom_range(1)));
			queue_item(CMD_WR_RES, i[INDEX_W-1:0], $urandom >> $urandom_range(32),
				$urandom, 1'($urandom_range(1)));
		end
		queue_random(60);
		drain();

		set_config(32'h3FFF_FFFF, '0, 32'hFFFF_FFFF);
		queue_item(CMD_WR_VOLT, 7'd127, '1, '0, 1'b0);
		queue_item(CMD_WR_RES, 7'd127, '1, '0, 1'b0);
		queue_item(CMD_INIT, 7'd0, '0, '0, 1'b0);
		queue_item(CMD_STEP, 7'd0, '0, '1, 1'b1);
		queue_item(CMD_STEP, 7'd0, '0, '0, 1'b0);
		queue_item(CMD_STEP, 7'd0, '0, '1, 1'b0);
		queue_item(CMD_STEP, 7'd0, '0, '0, 1'b1);
		queue_item(CMD_WR_VOLT, 7'd0, '1, '0, 1'b0);
		queue_item(CMD_WR_RES, 7'd0, '0, '0, 1'b0);
		queue_item(CMD_STEP, 7'd0, '0, 32'd1, 1'b1);
		queue_item(CMD_STEP, 7'd0, '0, '1, 1'b0);
		queue_item(CMD_INIT, '1, '1, '1, 1'b1);
		queue_item(CMD_WR_VOLT, 7'd127, 32'd1000, '0, 1'b0);
		queue_item(CMD_STEP, 7'd0, '0, 32'h0001_0000, 1'b0);
		queue_item(CMD_WR_VOLT, 7'd127, '1, '0, 1'b0);
		queue_item(CMD_STEP, '1, '1, 32'd5, 1'b1);
		drain();

		set_config('0, '0, '0);
		queue_random(80);
		drain();

		set_config('1, '1, '1);
		queue_random(120);
		drain();

		repeat (4) begin
			set_config($urandom, $urandom >> $urandom_range(8, 32),
				$urandom >> $urandom_range(0, 12));
			queue_random(140);
			drain();
		end

		repeat (16) @(posedge clk);
		fault_count += awaited_readings.size();
		if (fault_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
